/* hdl/tlbpt_pkg.sv */
// Shared types and constants for the TLB page table translator.
// Used by the controller, datapath and top level; no dependencies.
`default_nettype none

package tlbpt_pkg;

  localparam int ADDR_W          = 16;
  localparam int PHYS_W          = 15;
  localparam int PAGE_COUNT      = 256;
  localparam int PAGE_BYTES      = 256;
  localparam int PAGE_W          = $clog2(PAGE_COUNT);
  localparam int OFFSET_W        = $clog2(PAGE_BYTES);
  localparam int CNT_W           = 32;
  localparam int TLB_ENTRIES_DEF = 16;
  localparam int FRAME_COUNT_DEF = 128;

  // controller to datapath
  typedef struct packed {
    logic capture;  // word accepted this cycle: latch address, start memory reads
    logic exec;     // resolve translation and commit state
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skid_full;  // second result slot occupied, hold off new words
  } dp_status_t;

endpackage

`default_nettype wire

/* hdl/tlbpt_ctrl.sv */
// Controller for the TLB page table translator: two-state sequencer.
// Depends on tlbpt_pkg for the command and status structs.
`default_nettype none

module tlbpt_ctrl import tlbpt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  assign in_ready    = (state == S_IDLE) && !status.skid_full;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state == S_EXEC);

  always_comb begin
    case (state)
      S_IDLE:  state_next = cmd.capture ? S_EXEC : S_IDLE;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/tlbpt_datapath.sv */
// Datapath for the TLB page table translator: TLB, page table memories,
// FIFO frame allocation, counters and a two-slot result queue.
// Depends on tlbpt_pkg.
`default_nettype none

module tlbpt_datapath import tlbpt_pkg::*; #(
  parameter int TLB_ENTRIES   = TLB_ENTRIES_DEF,
  parameter int FRAME_COUNT_P = FRAME_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  input  logic [ADDR_W-1:0]   virt_addr,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PHYS_W-1:0]   phys_addr,
  output logic                tlb_hit,
  output logic                page_fault,
  output logic                evicted_valid,
  output logic [PAGE_W-1:0]   victim_page,
  output logic [CNT_W-1:0]    fault_total,
  output logic [CNT_W-1:0]    hit_total
);

  localparam int FW     = $clog2(FRAME_COUNT_P);
  localparam int FUW    = $clog2(FRAME_COUNT_P + 1);
  localparam int TIW    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int FULL_W = FW + OFFSET_W;

  typedef struct packed {
    logic [PHYS_W-1:0] phys;
    logic              hit;
    logic              fault;
    logic              ev_valid;
    logic [PAGE_W-1:0] ev_page;
    logic [CNT_W-1:0]  faults;
    logic [CNT_W-1:0]  hits;
  } result_t;

  // page table memories
  logic [FW-1:0]     page_frame_map   [PAGE_COUNT];
  logic [PAGE_W-1:0] frame_owner_page [FRAME_COUNT_P];
  logic [PAGE_COUNT-1:0] page_resident;

  // TLB
  logic [PAGE_W-1:0]      tlb_page_tag    [TLB_ENTRIES];
  logic [FW-1:0]          tlb_frame_entry [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_entry_valid;
  logic [TIW-1:0]         tlb_fill_pointer;

  logic [FUW-1:0]   frames_in_use;
  logic [FW-1:0]    victim_pointer;
  logic [CNT_W-1:0] fault_counter;
  logic [CNT_W-1:0] hit_counter;

  logic [PAGE_W-1:0]   page_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [FW-1:0]       map_q;
  logic [PAGE_W-1:0]   owner_q;

  logic [PAGE_W-1:0] in_page;
  assign in_page = virt_addr[OFFSET_W +: PAGE_W];

  // lookup and resolve
  logic [TLB_ENTRIES-1:0] match;
  logic [TLB_ENTRIES-1:0] inv;
  logic                   hit;
  logic [FW-1:0]          tlb_frame_sel;
  logic                   fault;
  logic                   room;
  logic                   evict;
  logic [FW-1:0]          new_frame;
  logic [FW-1:0]          frame;
  logic [PAGE_W-1:0]      ev_page;
  logic [CNT_W-1:0]       fault_counter_next;
  logic [CNT_W-1:0]       hit_counter_next;
  logic [FULL_W+PHYS_W-1:0] phys_ext;
  result_t                res;

  always_comb begin
    tlb_frame_sel = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      match[i] = tlb_entry_valid[i] && (tlb_page_tag[i] == page_q);
      inv[i]   = tlb_entry_valid[i] && (tlb_page_tag[i] == owner_q);
      // scan down so the lowest matching entry wins
      if (match[i]) begin
        tlb_frame_sel = tlb_frame_entry[i];
      end
    end
  end

  assign hit       = |match;
  assign fault     = !hit && !page_resident[page_q];
  assign room      = frames_in_use < FUW'(FRAME_COUNT_P);
  assign evict     = fault && !room;
  assign new_frame = room ? frames_in_use[FW-1:0] : victim_pointer;
  assign frame     = hit ? tlb_frame_sel : (fault ? new_frame : map_q);
  assign ev_page   = evict ? owner_q : '0;

  assign fault_counter_next = fault_counter + CNT_W'(fault);
  assign hit_counter_next   = hit_counter + CNT_W'(hit);

  assign phys_ext = {{PHYS_W{1'b0}}, frame, offset_q};

  assign res.phys     = phys_ext[PHYS_W-1:0];
  assign res.hit      = hit;
  assign res.fault    = fault;
  assign res.ev_valid = evict;
  assign res.ev_page  = ev_page;
  assign res.faults   = fault_counter_next;
  assign res.hits     = hit_counter_next;

  // memory ports: read on capture, write on a fault
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      map_q <= page_frame_map[in_page];
    end
    if (cmd.exec && fault) begin
      page_frame_map[page_q] <= new_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      owner_q <= frame_owner_page[victim_pointer];
    end
    if (cmd.exec && fault) begin
      frame_owner_page[new_frame] <= page_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_q   <= in_page;
      offset_q <= virt_addr[OFFSET_W-1:0];
    end
  end

  // TLB payload needs no reset
  always_ff @(posedge clk) begin
    if (cmd.exec && !hit) begin
      tlb_page_tag[tlb_fill_pointer]    <= page_q;
      tlb_frame_entry[tlb_fill_pointer] <= frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_resident    <= '0;
      tlb_entry_valid  <= '0;
      tlb_fill_pointer <= '0;
      frames_in_use    <= '0;
      victim_pointer   <= '0;
      fault_counter    <= '0;
      hit_counter      <= '0;
    end else if (cmd.exec) begin
      fault_counter <= fault_counter_next;
      hit_counter   <= hit_counter_next;
      if (fault) begin
        page_resident[page_q] <= 1'b1;
        if (room) begin
          frames_in_use <= frames_in_use + FUW'(1);
        end else begin
          page_resident[owner_q] <= 1'b0;
          victim_pointer <= (victim_pointer == FW'(FRAME_COUNT_P - 1)) ?
                            '0 : victim_pointer + FW'(1);
        end
      end
      if (!hit) begin
        // drop entries of the evicted page, then fill the next slot
        tlb_entry_valid <= (evict ? (tlb_entry_valid & ~inv) : tlb_entry_valid) |
                           (TLB_ENTRIES'(1) << tlb_fill_pointer);
        tlb_fill_pointer <= (tlb_fill_pointer == TIW'(TLB_ENTRIES - 1)) ?
                            '0 : tlb_fill_pointer + TIW'(1);
      end
    end
  end

  // two-slot result queue: output register plus skid slot
  result_t out_q;
  result_t skid_q;
  logic    skid_full;
  logic    pop;

  assign pop              = out_valid && out_ready;
  assign status.skid_full = skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (cmd.exec) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (pop) begin
      if (skid_full) begin
        skid_full <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (!out_valid || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (pop && skid_full) begin
      out_q <= skid_q;
    end
  end

  assign phys_addr     = out_q.phys;
  assign tlb_hit       = out_q.hit;
  assign page_fault    = out_q.fault;
  assign evicted_valid = out_q.ev_valid;
  assign victim_page   = out_q.ev_page;
  assign fault_total   = out_q.faults;
  assign hit_total     = out_q.hits;

endmodule

`default_nettype wire

/* hdl/tlb_page_table_translator_core.sv */
// Top level of the TLB page table translator.
// Instantiates tlbpt_ctrl and tlbpt_datapath; depends on tlbpt_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one logical address per word;
//   bits above the offset select the page, the low bits are the offset.
//   Output channel (out_valid/out_ready) returns one word per input: the
//   physical address, TLB hit, page fault and eviction flags, and running
//   fault and hit totals (32 bits, wrapping).
//   Each word is accepted while the page table and frame owner memories
//   are read; then the TLB is searched, the frame resolved and state
//   written back. The synchronous page table read forces this split; no
//   new word is accepted until the previous one is resolved. The result
//   is registered into the output register, or the skid slot if busy.
//   Results go into a two-slot queue, so a word is still accepted while one
//   result waits; when both slots are full, in_ready stays low until the
//   receiver takes a word.
//   Reset clears the TLB valid bits, page residency, frame allocation,
//   victim pointer and counters at once; no clearing pass is needed.
//   Frames are handed out in order, then reused oldest first; an evicted
//   page's TLB entries are invalidated. TLB misses refill round-robin.
`default_nettype none

module tlb_page_table_translator_core import tlbpt_pkg::*; #(
  parameter int TLB_ENTRIES   = TLB_ENTRIES_DEF,
  parameter int FRAME_COUNT_P = FRAME_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ADDR_W-1:0] virt_addr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PHYS_W-1:0] phys_addr,
  output logic              tlb_hit,
  output logic              page_fault,
  output logic              evicted_valid,
  output logic [PAGE_W-1:0] victim_page,
  output logic [CNT_W-1:0]  fault_total,
  output logic [CNT_W-1:0]  hit_total
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tlbpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tlbpt_datapath #(
    .TLB_ENTRIES   (TLB_ENTRIES),
    .FRAME_COUNT_P (FRAME_COUNT_P)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .virt_addr     (virt_addr),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .phys_addr     (phys_addr),
    .tlb_hit       (tlb_hit),
    .page_fault    (page_fault),
    .evicted_valid (evicted_valid),
    .victim_page   (victim_page),
    .fault_total   (fault_total),
    .hit_total     (hit_total)
  );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for tlb_page_table_translator_core.
// Holds a scoreboard class with its own TLB and FIFO paging predictor and
// drives both valid/ready channels with random gaps; depends on tlbpt_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tlbpt_pkg::*;

  localparam int TLB_SLOTS      = TLB_ENTRIES_DEF;
  localparam int FRAME_SLOTS    = FRAME_COUNT_DEF;
  localparam int FRAME_W        = $clog2(FRAME_SLOTS);
  localparam int RANDOM_WORDS   = 600;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [PHYS_W-1:0] phys_addr;
    logic              tlb_hit;
    logic              page_fault;
    logic              evicted_valid;
    logic [PAGE_W-1:0] victim_page;
    logic [CNT_W-1:0]  fault_total;
    logic [CNT_W-1:0]  hit_total;
  } xlate_word_t;

  class xlate_scoreboard;
    logic [FRAME_W-1:0] frame_of_page [PAGE_COUNT];
    bit                 page_in_memory [PAGE_COUNT];
    logic [PAGE_W-1:0]  tlb_tag [TLB_SLOTS];
    logic [FRAME_W-1:0] tlb_frame [TLB_SLOTS];
    bit                 tlb_live [TLB_SLOTS];
    logic [PAGE_W-1:0]  frame_owner [FRAME_SLOTS];
    int unsigned        tlb_fill;
    int unsigned        frames_used;
    int unsigned        victim;
    logic [CNT_W-1:0]   fault_count;
    logic [CNT_W-1:0]   hit_count;
    xlate_word_t        expected_q[$];
    int unsigned        mismatches;

    function new();
      foreach (page_in_memory[i]) page_in_memory[i] = 1'b0;
      foreach (tlb_live[i]) tlb_live[i] = 1'b0;
      tlb_fill    = 0;
      frames_used = 0;
      victim      = 0;
      fault_count = '0;
      hit_count   = '0;
      mismatches  = 0;
    endfunction

    // Translate one accepted address and queue the word it must produce.
    function void note_address(logic [ADDR_W-1:0] addr);
      logic [PAGE_W-1:0]   page;
      logic [OFFSET_W-1:0] offset;
      logic [FRAME_W-1:0]  frame;
      logic [PAGE_W-1:0]   old_page;
      xlate_word_t         w;
      bit                  found;
      page   = addr[OFFSET_W +: PAGE_W];
      offset = addr[OFFSET_W-1:0];
      frame  = '0;
      found  = 1'b0;
      w      = '0;
      // lowest matching slot wins
      for (int i = 0; i < TLB_SLOTS; i++) begin
        if (!found && tlb_live[i] && tlb_tag[i] == page) begin
          found = 1'b1;
          frame = tlb_frame[i];
        end
      end
      if (found) begin
        hit_count++;
        w.tlb_hit = 1'b1;
      end else begin
        if (!page_in_memory[page]) begin
          w.page_fault = 1'b1;
          fault_count++;
          if (frames_used < FRAME_SLOTS) begin
            frame = FRAME_W'(frames_used);
            frames_used++;
          end else begin
            // reuse the oldest frame and drop its page from the TLB
            frame = FRAME_W'(victim);
            old_page = frame_owner[victim];
            w.evicted_valid = 1'b1;
            w.victim_page   = old_page;
            page_in_memory[old_page] = 1'b0;
            for (int i = 0; i < TLB_SLOTS; i++) begin
              if (tlb_live[i] && tlb_tag[i] == old_page) tlb_live[i] = 1'b0;
            end
            victim = (victim + 1) % FRAME_SLOTS;
          end
          frame_owner[frame]   = page;
          frame_of_page[page]  = frame;
          page_in_memory[page] = 1'b1;
        end
        frame = frame_of_page[page];
        tlb_tag[tlb_fill]   = page;
        tlb_frame[tlb_fill] = frame;
        tlb_live[tlb_fill]  = 1'b1;
        tlb_fill = (tlb_fill + 1) % TLB_SLOTS;
      end
      w.phys_addr   = PHYS_W'(int'(frame) * PAGE_BYTES + int'(offset));
      w.fault_total = fault_count;
      w.hit_total   = hit_count;
      expected_q.push_back(w);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb_top: %s mismatch, expected %0h, actual %0h", name, want, seen);
      end
    endfunction

    function void check_result(xlate_word_t got);
      xlate_word_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb_top: result word with nothing pending, actual %0h", got);
        return;
      end
      want = expected_q.pop_front();
      check_field("phys_addr", want.phys_addr, got.phys_addr);
      check_field("tlb_hit", want.tlb_hit, got.tlb_hit);
      check_field("page_fault", want.page_fault, got.page_fault);
      check_field("evicted_valid", want.evicted_valid, got.evicted_valid);
      check_field("victim_page", want.victim_page, got.victim_page);
      check_field("fault_total", want.fault_total, got.fault_total);
      check_field("hit_total", want.hit_total, got.hit_total);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Page that the next fault will evict, or any page while frames are free.
    function logic [PAGE_W-1:0] next_victim_page();
      if (frames_used == FRAME_SLOTS) return frame_owner[victim];
      return PAGE_W'($urandom_range(PAGE_COUNT - 1));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ADDR_W-1:0] virt_addr = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PHYS_W-1:0] phys_addr;
  logic              tlb_hit;
  logic              page_fault;
  logic              evicted_valid;
  logic [PAGE_W-1:0] victim_page;
  logic [CNT_W-1:0]  fault_total;
  logic [CNT_W-1:0]  hit_total;

  xlate_scoreboard   sb = new();
  bit                no_gaps = 1'b0;
  int unsigned       stall_left = 0;
  int unsigned       stuck_cycles = 0;
  logic [ADDR_W-1:0] walk_q[$];

  tlb_page_table_translator_core #(
    .TLB_ENTRIES  (TLB_SLOTS),
    .FRAME_COUNT_P(FRAME_SLOTS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .virt_addr    (virt_addr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .phys_addr    (phys_addr),
    .tlb_hit      (tlb_hit),
    .page_fault   (page_fault),
    .evicted_valid(evicted_valid),
    .victim_page  (victim_page),
    .fault_total  (fault_total),
    .hit_total    (hit_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic send_word(logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    virt_addr <= addr;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_address(addr);
  endtask

  // Hold off the sender until every pending word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result({phys_addr, tlb_hit, page_fault, evicted_valid,
                         victim_page, fault_total, hit_total});
      if (stall_left == 0 && !no_gaps && $urandom_range(3) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WATCHDOG_LIMIT) begin
        $display("tb_top: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned         r;
    int unsigned         scan_left;
    int unsigned         lo;
    logic [PAGE_W-1:0]   page;
    logic [PAGE_W-1:0]   scan_page;
    logic [OFFSET_W-1:0] offset;
    logic [PAGE_W-1:0]   recent_q[$];

    scan_left = 0;
    scan_page = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // offsets at both ends, top and bottom pages, then walk 16 pages to wrap
    // the TLB fill pointer and come back to page 0 through the page table
    walk_q = '{16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'h8001, 16'h7FFE};
    for (int p = 1; p <= 16; p++)
      walk_q.push_back({PAGE_W'(p), OFFSET_W'(p * 17)});
    walk_q.push_back(16'h0012);
    foreach (walk_q[i]) send_word(walk_q[i]);
    drain_results();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      no_gaps = (i >= 200 && i < 280);
      if (i == 320) drain_results();
      if (scan_left > 0) begin
        page = scan_page;
        scan_page++;
        scan_left--;
      end else begin
        r = $urandom_range(99);
        if (r < 30 && recent_q.size() > 0) begin
          // hot pages, most likely still in the TLB
          lo = (recent_q.size() > 8) ? recent_q.size() - 8 : 0;
          page = recent_q[$urandom_range(recent_q.size() - 1, lo)];
        end else if (r < 50 && recent_q.size() > 0) begin
          page = recent_q[$urandom_range(recent_q.size() - 1)];
        end else if (r < 58) begin
          // touch the next eviction victim so it sits in the TLB when it goes
          page = sb.next_victim_page();
        end else if (r < 62) begin
          scan_page = PAGE_W'($urandom_range(PAGE_COUNT - 1));
          scan_left = $urandom_range(20, 4);
          page = scan_page;
          scan_page++;
        end else begin
          page = PAGE_W'($urandom_range(PAGE_COUNT - 1));
        end
      end
      r = $urandom_range(9);
      if (r == 0) offset = '0;
      else if (r == 1) offset = '1;
      else offset = OFFSET_W'($urandom_range(PAGE_BYTES - 1));
      recent_q.push_back(page);
      if (recent_q.size() > 64) void'(recent_q.pop_front());
      send_word({page, offset});
    end

    no_gaps = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
